### hdl/pqm_pkg.sv
// Shared types, constants and helpers of the process queue manager.
// Used by pqm_cell, pqm_row and process_queue_manager; no dependencies.
`default_nettype none

package pqm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 8;
  localparam int NUM_QUEUES  = 4;
  localparam int PRI_W       = 4;
  localparam int PID_PORT_W  = 8;
  localparam int POS_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PRI_W-1:0] MAX_PRIORITY = PRI_W'(9);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_SETPRI = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_PRI   = 2'd2,
    ST_FULL_DUP  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ROW_NOP    = 2'd0,
    ROW_INSERT = 2'd1,
    ROW_REMOVE = 2'd2,
    ROW_WRITE  = 2'd3
  } row_op_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    logic [PRI_W-1:0]    pri;
    logic [ID_WIDTH-1:0] id;
  } entry_t;

  // Per-queue status seen by the controller.
  typedef struct packed {
    logic              hit;
    logic [POS_W-1:0]  hit_pos;
    logic [PRI_W-1:0]  hit_pri;
    logic              full;
    logic [POS_W-1:0]  ins_pos;
    logic [CNT_W-1:0]  cnt;
  } row_stat_t;

  function automatic logic [3:0] pos4(input logic [POS_W-1:0] p);
    logic [POS_W+3:0] e;
    e = {4'b0, p};
    return e[3:0];
  endfunction

  function automatic logic [ID_WIDTH-1:0] to_id(input logic [PID_PORT_W-1:0] v);
    logic [ID_WIDTH+PID_PORT_W-1:0] e;
    e = {{ID_WIDTH{1'b0}}, v};
    return e[ID_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/pqm_cell.sv
// One queue slot: holds an entry, compares it against the search key and
// takes data from itself, a neighbor or the new entry. Uses pqm_pkg.
`default_nettype none

module pqm_cell (
  input  wire logic                          clk,
  input  wire pqm_pkg::cell_cmd_t            cmd,
  input  wire pqm_pkg::entry_t               left,
  input  wire pqm_pkg::entry_t               right,
  input  wire pqm_pkg::entry_t               load_val,
  input  wire logic [pqm_pkg::ID_WIDTH-1:0]  key_id,
  input  wire logic [pqm_pkg::PRI_W-1:0]     key_pri,
  output pqm_pkg::entry_t                    ent,
  output logic                               match,
  output logic                               greater
);
  import pqm_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_LOAD:  ent <= load_val;
      CELL_LEFT:  ent <= left;
      CELL_RIGHT: ent <= right;
      default:    ent <= ent;
    endcase
  end

  assign match   = (ent.id == key_id);
  assign greater = (ent.pri > key_pri);

endmodule

`default_nettype wire

### hdl/pqm_row.sv
// One bounded queue: a row of pqm_cell slots plus its fill count.
// Insert shifts the tail right, remove shifts it left. Uses pqm_pkg, pqm_cell.
`default_nettype none

module pqm_row (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sorted,
  input  wire pqm_pkg::row_op_t              op,
  input  wire logic [pqm_pkg::POS_W-1:0]     pos,
  input  wire logic [pqm_pkg::ID_WIDTH-1:0]  key_id,
  input  wire logic [pqm_pkg::PRI_W-1:0]     key_pri,
  output pqm_pkg::row_stat_t                 stat
);
  import pqm_pkg::*;

  entry_t           ent     [QUEUE_DEPTH];
  logic             match   [QUEUE_DEPTH];
  logic             greater [QUEUE_DEPTH];
  logic             vld     [QUEUE_DEPTH];
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] ins_pos;
  entry_t           new_ent;

  assign new_ent = '{pri: key_pri, id: key_id};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [POS_W-1:0] IDX = POS_W'(i);
    cell_cmd_t cmd;
    entry_t    left;
    entry_t    right;

    if (i == 0) begin : g_first
      assign left = new_ent;
    end else begin : g_mid_l
      assign left = ent[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = ent[i];
    end else begin : g_mid_r
      assign right = ent[i+1];
    end

    assign vld[i] = (CNT_W'(i) < cnt);

    always_comb begin
      cmd = CELL_HOLD;
      case (op)
        ROW_INSERT: begin
          if (IDX == ins_pos) cmd = CELL_LOAD;
          else if (IDX > ins_pos) cmd = CELL_LEFT;
        end
        ROW_REMOVE: begin
          if (IDX >= pos) cmd = CELL_RIGHT;
        end
        ROW_WRITE: begin
          if (IDX == pos) cmd = CELL_LOAD;
        end
        default: ;
      endcase
    end

    pqm_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .left     (left),
      .right    (right),
      .load_val (new_ent),
      .key_id   (key_id),
      .key_pri  (key_pri),
      .ent      (ent[i]),
      .match    (match[i]),
      .greater  (greater[i])
    );
  end

  // Front-most match, and insert position: first occupied slot ranking after the key (sorted rows), else the tail.
  always_comb begin
    stat.hit     = 1'b0;
    stat.hit_pos = '0;
    stat.hit_pri = '0;
    ins_pos      = cnt[POS_W-1:0];
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (vld[i] && match[i]) begin
        stat.hit     = 1'b1;
        stat.hit_pos = POS_W'(i);
        stat.hit_pri = ent[i].pri;
      end
      if (sorted && vld[i] && greater[i]) ins_pos = POS_W'(i);
    end
    stat.full    = (cnt == CNT_W'(QUEUE_DEPTH));
    stat.ins_pos = ins_pos;
    stat.cnt     = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (op)
        ROW_INSERT: cnt <= cnt + CNT_W'(1);
        ROW_REMOVE: cnt <= cnt - CNT_W'(1);
        default:    cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/process_queue_manager.sv
// Process queue manager top level: four pqm_row queues and the controller.
// Depends on pqm_pkg, pqm_row (and through it pqm_cell).
//
// Usage:
//   Request channel (req_valid / req_stall): one operation per transaction,
//   fields func, process_id, priority_req, is_blocked, is_suspended.
//   Response channel (rsp_valid / rsp_stall): exactly one result per
//   request, fields status, queue_index, found_priority, position.
//   The request is registered on acceptance; the result is registered in
//   the search state, and a set priority on a ready-queue entry adds a
//   place state (remove pass, then re-insert pass through the same cell row).
//   A new request is taken only once the previous one is done. All slots
//   of all queues compare against the key combinationally in the search
//   state; the shift of one row happens there (the re-insert in the place state).
//   req_stall is high while a request is in progress. The result sits in
//   an output register, so a stalled response does not hold off the next
//   request; only the search state of that next request waits for it.
//   Reset (rst, synchronous) empties all four queues; slot contents are
//   left as they are and never read before being written.
`default_nettype none

module process_queue_manager (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] func,
  input  wire logic [7:0] process_id,
  input  wire logic [3:0] priority_req,
  input  wire logic       is_blocked,
  input  wire logic       is_suspended,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic [1:0]      status,
  output logic [1:0]      queue_index,
  output logic [3:0]      found_priority,
  output logic [3:0]      position
);
  import pqm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_PLACE
  } state_t;

  state_t              state, state_next;
  func_t               func_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [PRI_W-1:0]    pri_r;
  logic [1:0]          tq;
  logic [1:0]          q_r, q_next;

  row_op_t             row_op   [NUM_QUEUES];
  row_stat_t           rstat    [NUM_QUEUES];
  logic [POS_W-1:0]    op_pos;

  logic                hit_any;
  logic [1:0]          hq;
  logic [POS_W-1:0]    hpos;
  logic [PRI_W-1:0]    hpri;

  logic                rsp_free;
  logic                emit;
  status_t             st_next;
  logic [1:0]          qi_next;
  logic [3:0]          fp_next;
  logic [3:0]          ps_next;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_row
    pqm_row u_row (
      .clk     (clk),
      .rst     (rst),
      .sorted  ((q % 2) == 0),
      .op      (row_op[q]),
      .pos     (op_pos),
      .key_id  (id_r),
      .key_pri (pri_r),
      .stat    (rstat[q])
    );
  end

  // First hit in queue order 0..3
  always_comb begin
    hit_any = 1'b0;
    hq      = '0;
    hpos    = '0;
    hpri    = '0;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      if (rstat[q].hit) begin
        hit_any = 1'b1;
        hq      = 2'(q);
        hpos    = rstat[q].hit_pos;
        hpri    = rstat[q].hit_pri;
      end
    end
  end

  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) row_op[q] = ROW_NOP;
    op_pos     = hpos;
    state_next = state;
    q_next     = q_r;
    emit       = 1'b0;
    st_next    = ST_OK;
    qi_next    = '0;
    fp_next    = '0;
    ps_next    = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (rsp_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (func_r == FUNC_INSERT) begin
            if (hit_any) begin
              st_next = ST_FULL_DUP;
              qi_next = hq;
              fp_next = hpri;
              ps_next = pos4(hpos);
            end else if (rstat[tq].full) begin
              st_next = ST_FULL_DUP;
              qi_next = tq;
              fp_next = pri_r;
            end else begin
              row_op[tq] = ROW_INSERT;
              qi_next    = tq;
              fp_next    = pri_r;
              ps_next    = pos4(rstat[tq].ins_pos);
            end
          end else if (!hit_any) begin
            st_next = ST_NOT_FOUND;
          end else begin
            qi_next = hq;
            fp_next = hpri;
            ps_next = pos4(hpos);
            case (func_r)
              FUNC_REMOVE: row_op[hq] = ROW_REMOVE;
              FUNC_SETPRI: begin
                if (pri_r > MAX_PRIORITY) begin
                  st_next = ST_BAD_PRI;
                end else if (!hq[0]) begin
                  // ready queue: pull out now, re-insert in sorted place next
                  row_op[hq] = ROW_REMOVE;
                  q_next     = hq;
                  emit       = 1'b0;
                  state_next = S_PLACE;
                end else begin
                  row_op[hq] = ROW_WRITE;
                  fp_next    = pri_r;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_PLACE: begin
        if (rsp_free) begin
          row_op[q_r] = ROW_INSERT;
          emit        = 1'b1;
          qi_next     = q_r;
          fp_next     = pri_r;
          ps_next     = pos4(rstat[q_r].ins_pos);
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      q_r   <= q_next;
      if (state == S_IDLE && req_valid) begin
        func_r <= func_t'(func);
        id_r   <= to_id(process_id);
        pri_r  <= priority_req;
        tq     <= {is_suspended, is_blocked};
      end
      if (emit) begin
        rsp_valid      <= 1'b1;
        status         <= st_next;
        queue_index    <= qi_next;
        found_priority <= fp_next;
        position       <= ps_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  logic [NUM_QUEUES-1:0] row_busy;
  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) row_busy[q] = (row_op[q] != ROW_NOP);
  end

  a_one_row_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0(row_busy))
    else $error("more than one queue modified in a cycle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    rstat[0].cnt <= CNT_W'(QUEUE_DEPTH) && rstat[1].cnt <= CNT_W'(QUEUE_DEPTH) &&
    rstat[2].cnt <= CNT_W'(QUEUE_DEPTH) && rstat[3].cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_place_room: assert property (@(posedge clk) disable iff (rst)
    state == S_PLACE |-> !rstat[q_r].full)
    else $error("re-insert into a full queue");

  a_take_search: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == S_SEARCH)
    else $error("accepted request not searched");
`endif

endmodule

`default_nettype wire

### tb/sv/process_queue_manager_tb.sv
// Testbench for process_queue_manager: directed and random queue operations,
// checked against a behavioral model of the four process queues kept here.
// Depends on pqm_pkg and the process_queue_manager RTL.
`timescale 1ns / 100ps

module process_queue_manager_tb;
  import pqm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] qidx;
    logic [3:0] pri;
    logic [3:0] pos;
  } queue_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [1:0] func = 2'd0;
  logic [7:0] process_id = 8'd0;
  logic [3:0] priority_req = 4'd0;
  logic       is_blocked = 1'b0;
  logic       is_suspended = 1'b0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [1:0] status;
  logic [1:0] queue_index;
  logic [3:0] found_priority;
  logic [3:0] position;

  // Shadow copy of the four queues
  logic [ID_WIDTH-1:0] mdl_id [NUM_QUEUES][QUEUE_DEPTH];
  logic [3:0]          mdl_pri [NUM_QUEUES][QUEUE_DEPTH];
  int                  mdl_len [NUM_QUEUES];

  queue_result_t awaited_results[$];
  int            mismatch_count = 0;
  int            stuck_cycles = 0;
  int            req_gap_pct = 0;
  int            rsp_gap_pct = 0;
  int            rsp_hold_len = 0;

  process_queue_manager uut (.*);

  always #5 clk = ~clk;

  function automatic queue_result_t make_result(status_t st, int q, logic [3:0] pri, int pos);
    queue_result_t r;
    r.status = st;
    r.qidx   = 2'(q);
    r.pri    = pri;
    r.pos    = 4'(pos);
    return r;
  endfunction

  // Ready queues (even index) sort by priority, new entry after equal ones;
  // blocked queues append at the back.
  function automatic int model_place(int q, logic [ID_WIDTH-1:0] id, logic [3:0] pri);
    int n;
    int p;
    n = mdl_len[q];
    p = n;
    if (q % 2 == 0) begin
      for (int i = 0; i < n; i++) begin
        if (mdl_pri[q][i] > pri) begin
          p = i;
          break;
        end
      end
    end
    for (int i = n; i > p; i--) begin
      mdl_id[q][i]  = mdl_id[q][i-1];
      mdl_pri[q][i] = mdl_pri[q][i-1];
    end
    mdl_id[q][p]  = id;
    mdl_pri[q][p] = pri;
    mdl_len[q]    = n + 1;
    return p;
  endfunction

  function automatic void model_take_out(int q, int p);
    for (int i = p; i + 1 < mdl_len[q]; i++) begin
      mdl_id[q][i]  = mdl_id[q][i+1];
      mdl_pri[q][i] = mdl_pri[q][i+1];
    end
    mdl_len[q] = mdl_len[q] - 1;
  endfunction

  function automatic queue_result_t predict_queue_op(func_t op, logic [7:0] pid,
                                                     logic [3:0] pri, logic blk, logic sus);
    logic [ID_WIDTH-1:0] id;
    logic [3:0]          old_pri;
    int                  q;
    int                  p;
    bit                  hit;
    id  = pid[ID_WIDTH-1:0];
    hit = 1'b0;
    q   = 0;
    p   = 0;
    // search order: queue 0..3, front to back
    for (int i = 0; i < NUM_QUEUES && !hit; i++) begin
      for (int j = 0; j < mdl_len[i] && !hit; j++) begin
        if (mdl_id[i][j] == id) begin
          hit = 1'b1;
          q   = i;
          p   = j;
        end
      end
    end
    if (op == FUNC_INSERT) begin
      if (hit)
        return make_result(ST_FULL_DUP, q, mdl_pri[q][p], p);
      q = {sus, blk};
      if (mdl_len[q] >= QUEUE_DEPTH)
        return make_result(ST_FULL_DUP, q, pri, 0);
      p = model_place(q, id, pri);
      return make_result(ST_OK, q, pri, p);
    end
    if (!hit)
      return make_result(ST_NOT_FOUND, 0, 4'd0, 0);
    old_pri = mdl_pri[q][p];
    case (op)
      FUNC_REMOVE: begin
        model_take_out(q, p);
        return make_result(ST_OK, q, old_pri, p);
      end
      FUNC_FIND: return make_result(ST_OK, q, old_pri, p);
      default: begin
        if (pri > MAX_PRIORITY)
          return make_result(ST_BAD_PRI, q, old_pri, p);
        if (q % 2 == 0) begin
          model_take_out(q, p);
          p = model_place(q, id, pri);
        end else begin
          mdl_pri[q][p] = pri;
        end
        return make_result(ST_OK, q, pri, p);
      end
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_request(func_t op, logic [7:0] pid, logic [3:0] pri,
                              logic blk, logic sus);
    bit taken;
    if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_valid    <= 1'b1;
    func         <= op;
    process_id   <= pid;
    priority_req <= pri;
    is_blocked   <= blk;
    is_suspended <= sus;
    do begin
      @(negedge clk);
      taken = (req_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
    awaited_results.push_back(predict_queue_op(op, pid, pri, blk, sus));
  endtask

  task automatic run_random(int n_items, int ins_w, int rem_w, int find_w,
                            int id_base, int id_span, int favor_q, bit with_gaps);
    int         r;
    int         qsel;
    func_t      op;
    logic [7:0] pid;
    logic [3:0] pri;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        if (with_gaps) begin
          case ($urandom_range(2))
            0: begin req_gap_pct = 0;  rsp_gap_pct = 0;  end
            1: begin req_gap_pct = 5;  rsp_gap_pct = 3;  end
            default: begin req_gap_pct = 25; rsp_gap_pct = 10; end
          endcase
        end else begin
          req_gap_pct = 0;
          rsp_gap_pct = 0;
        end
      end
      r = $urandom_range(99);
      if (r < ins_w)                      op = FUNC_INSERT;
      else if (r < ins_w + rem_w)         op = FUNC_REMOVE;
      else if (r < ins_w + rem_w + find_w) op = FUNC_FIND;
      else                                op = FUNC_SETPRI;
      if ($urandom_range(15) == 0)
        pid = 8'($urandom);
      else
        pid = 8'(id_base + $urandom_range(id_span - 1));
      if (op == FUNC_SETPRI && $urandom_range(99) < 85)
        pri = 4'($urandom_range(9));
      else
        pri = 4'($urandom_range(15));
      if (favor_q >= 0 && $urandom_range(99) < 70)
        qsel = favor_q;
      else
        qsel = $urandom_range(3);
      send_request(op, pid, pri, qsel[0], qsel[1]);
    end
  endtask

  task automatic test_directed_cases();
    req_gap_pct = 5;
    rsp_gap_pct = 3;
    send_request(FUNC_FIND,   8'd0,   4'd0,  1'b0, 1'b0);  // empty queues
    send_request(FUNC_REMOVE, 8'd255, 4'd15, 1'b1, 1'b1);
    send_request(FUNC_SETPRI, 8'd128, 4'd3,  1'b0, 1'b0);
    send_request(FUNC_INSERT, 8'd0,   4'd15, 1'b0, 1'b0);  // priority above 9 taken on insert
    send_request(FUNC_INSERT, 8'd255, 4'd0,  1'b0, 1'b0);
    send_request(FUNC_INSERT, 8'd1,   4'd15, 1'b0, 1'b0);  // goes after equal priority
    send_request(FUNC_INSERT, 8'd0,   4'd2,  1'b1, 1'b0);  // duplicate id
    send_request(FUNC_INSERT, 8'd170, 4'd5,  1'b1, 1'b0);
    send_request(FUNC_INSERT, 8'd85,  4'd0,  1'b1, 1'b0);  // FIFO, not sorted
    send_request(FUNC_INSERT, 8'd4,   4'd7,  1'b0, 1'b1);
    send_request(FUNC_INSERT, 8'd5,   4'd9,  1'b1, 1'b1);
    send_request(FUNC_FIND,   8'd5,   4'd0,  1'b0, 1'b0);
    send_request(FUNC_FIND,   8'd1,   4'd0,  1'b0, 1'b0);
    send_request(FUNC_SETPRI, 8'd255, 4'd10, 1'b0, 1'b0);  // bad priority
    send_request(FUNC_SETPRI, 8'd5,   4'd15, 1'b0, 1'b0);
    send_request(FUNC_SETPRI, 8'd255, 4'd9,  1'b0, 1'b0);  // ready entry moves
    send_request(FUNC_SETPRI, 8'd85,  4'd9,  1'b0, 1'b0);  // blocked entry stays put
    send_request(FUNC_SETPRI, 8'd0,   4'd0,  1'b0, 1'b0);
    send_request(FUNC_REMOVE, 8'd1,   4'd0,  1'b0, 1'b0);
    send_request(FUNC_REMOVE, 8'd170, 4'd0,  1'b0, 1'b0);
    send_request(FUNC_FIND,   8'd170, 4'd0,  1'b0, 1'b0);
    send_request(FUNC_FIND,   8'd85,  4'd0,  1'b0, 1'b0);
  endtask

  task automatic test_mixed_ops();
    run_random(800, 40, 20, 20, 0, 48, -1, 1'b1);
  endtask

  // Push each queue toward full, then empty them again.
  task automatic test_fill_and_drain();
    for (int q = 0; q < NUM_QUEUES; q++)
      run_random(90, 75, 5, 10, 176, 80, q, 1'b1);
    run_random(300, 15, 60, 10, 176, 80, -1, 1'b1);
  endtask

  task automatic test_output_backpressure();
    req_gap_pct  = 0;
    rsp_gap_pct  = 0;
    rsp_hold_len = HOLD_OFF_CYCLES;
    run_random(40, 40, 20, 20, 0, 48, -1, 1'b0);
  endtask

  task automatic test_full_rate();
    run_random(400, 40, 20, 20, 100, 60, -1, 1'b0);
  endtask

  initial begin : rsp_stall_driver
    int burst;
    forever begin
      @(posedge clk);
      if (rsp_hold_len > 0) begin
        rsp_stall <= 1'b1;
        repeat (rsp_hold_len) @(posedge clk);
        rsp_hold_len = 0;
        rsp_stall <= 1'b0;
      end else if (rsp_gap_pct != 0 && $urandom_range(99) < rsp_gap_pct) begin
        burst = $urandom_range(1, 18);
        rsp_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Outputs are sampled mid-cycle; a transaction seen here is taken at the next edge.
  always @(negedge clk) begin : result_check
    queue_result_t exp_r;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result transaction: status %0d queue %0d", status, queue_index);
        mismatch_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status);
          mismatch_count++;
        end
        if (queue_index !== exp_r.qidx) begin
          $error("queue_index: expected %0d, actual %0d", exp_r.qidx, queue_index);
          mismatch_count++;
        end
        if (found_priority !== exp_r.pri) begin
          $error("found_priority: expected %0d, actual %0d", exp_r.pri, found_priority);
          mismatch_count++;
        end
        if (position !== exp_r.pos) begin
          $error("position: expected %0d, actual %0d", exp_r.pos, position);
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    foreach (mdl_len[i]) mdl_len[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_mixed_ops();
    test_fill_and_drain();
    test_output_backpressure();
    test_full_rate();
    req_valid <= 1'b0;
    wait (awaited_results.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
